>>> rtl/isl_pkg.sv
// shared types and codes of the indexed shift list
package isl_pkg;

	localparam logic [2:0] KIND_APPEND = 3'd0;
	localparam logic [2:0] KIND_INSERT = 3'd1;
	localparam logic [2:0] KIND_REMOVE = 3'd2;
	localparam logic [2:0] KIND_SET    = 3'd3;
	localparam logic [2:0] KIND_GET    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic signed [31:0] BAD_READ = -32'sd1;

	typedef struct packed {
		logic [2:0]         kind;
		logic [6:0]         position;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [1:0]         status;
		logic [6:0]         entry_count;
	} res_t;

endpackage

>>> rtl/indexed_shift_list_top.sv
// indexed shift list: ordered list of signed words held in one synchronous memory
// append, set, rejected and unknown requests: result strobe in the cycle after the transfer
// get: memory read at the transfer, then S_GET registers the data into the result
// insert at end: as append; below it, entries move up in S_UP, one per cycle, then S_PUT
// remove: entries above move down in S_DN, one per cycle; busy holds off new transfers
// reset clears the count and the control state; the memory is not cleared
module indexed_shift_list_top
	import isl_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int AW = $clog2(CAPACITY);

	typedef enum logic [2:0] {S_IDLE, S_UP, S_PUT, S_DN, S_GET} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [XW-1:0]     ptr_q;
	logic [XW-1:0]     wa_s1;
	logic [XW-1:0]     pos_q;
	logic [31:0]       val_q;
	logic              done_q;
	res_t              res_q;

	logic [31:0]       mem [CAPACITY];
	logic [31:0]       rdata_s1;

	logic              accept;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic              full;
	logic              ins_bad;
	logic              rng_bad;
	logic [CW-1:0]     cnt_inc;
	logic [CW-1:0]     cnt_dec;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [31:0]       wdata;
	logic              re;
	logic [AW-1:0]     raddr;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign pos_x   = XW'(cmd.position);
	assign cnt_x   = XW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));
	assign ins_bad = (pos_x > cnt_x);
	assign rng_bad = (pos_x >= cnt_x);
	assign cnt_inc = count_q + CW'(1);
	assign cnt_dec = count_q - CW'(1);
	assign done    = done_q;
	assign result  = res_q;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						KIND_APPEND: begin
							if (!full) begin
								we    = 1'b1;
								waddr = AW'(count_q);
								wdata = cmd.value;
							end
						end
						KIND_INSERT: begin
							if (!ins_bad && !full) begin
								if (pos_x == cnt_x) begin
									we    = 1'b1;
									waddr = AW'(pos_x);
									wdata = cmd.value;
								end else begin
									re    = 1'b1;
									raddr = AW'(cnt_x - XW'(1));
								end
							end
						end
						KIND_REMOVE: begin
							if (!rng_bad && (pos_x + XW'(1) < cnt_x)) begin
								re    = 1'b1;
								raddr = AW'(pos_x + XW'(1));
							end
						end
						KIND_SET: begin
							if (!rng_bad) begin
								we    = 1'b1;
								waddr = AW'(pos_x);
								wdata = cmd.value;
							end
						end
						KIND_GET: begin
							if (!rng_bad) begin
								re    = 1'b1;
								raddr = AW'(pos_x);
							end
						end
						default: ;
					endcase
				end
			end
			S_UP: begin
				we    = 1'b1;
				waddr = AW'(wa_s1);
				wdata = rdata_s1;
				if (ptr_q > pos_q) begin
					re    = 1'b1;
					raddr = AW'(ptr_q - XW'(1));
				end
			end
			S_DN: begin
				we    = 1'b1;
				waddr = AW'(wa_s1);
				wdata = rdata_s1;
				if (ptr_q + XW'(1) < cnt_x) begin
					re    = 1'b1;
					raddr = AW'(ptr_q + XW'(1));
				end
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = AW'(pos_q);
				wdata = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			wa_s1   <= '0;
			pos_q   <= '0;
			val_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_q            <= 1'b1;
						res_q.read_data   <= '0;
						res_q.status      <= ST_OK;
						res_q.entry_count <= 7'(count_q);
						pos_q             <= pos_x;
						val_q             <= cmd.value;
						case (cmd.kind)
							KIND_APPEND: begin
								if (full) begin
									res_q.status <= ST_FULL;
								end else begin
									count_q           <= cnt_inc;
									res_q.entry_count <= 7'(cnt_inc);
								end
							end
							KIND_INSERT: begin
								if (ins_bad) begin
									res_q.status <= ST_RANGE;
								end else if (full) begin
									res_q.status <= ST_FULL;
								end else if (pos_x == cnt_x) begin
									count_q           <= cnt_inc;
									res_q.entry_count <= 7'(cnt_inc);
								end else begin
									done_q  <= 1'b0;
									state_q <= S_UP;
									wa_s1   <= cnt_x;
									ptr_q   <= cnt_x - XW'(1);
								end
							end
							KIND_REMOVE: begin
								if (rng_bad) begin
									res_q.status <= ST_RANGE;
								end else if (pos_x + XW'(1) < cnt_x) begin
									done_q  <= 1'b0;
									state_q <= S_DN;
									wa_s1   <= pos_x;
									ptr_q   <= pos_x + XW'(1);
								end else begin
									count_q           <= cnt_dec;
									res_q.entry_count <= 7'(cnt_dec);
								end
							end
							KIND_SET: begin
								if (rng_bad) begin
									res_q.status <= ST_RANGE;
								end
							end
							KIND_GET: begin
								if (rng_bad) begin
									res_q.status    <= ST_RANGE;
									res_q.read_data <= BAD_READ;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_GET;
								end
							end
							default: ;
						endcase
					end
				end
				S_UP: begin
					if (ptr_q > pos_q) begin
						wa_s1 <= ptr_q;
						ptr_q <= ptr_q - XW'(1);
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q           <= cnt_inc;
					done_q            <= 1'b1;
					res_q.read_data   <= '0;
					res_q.status      <= ST_OK;
					res_q.entry_count <= 7'(cnt_inc);
					state_q           <= S_IDLE;
				end
				S_DN: begin
					if (ptr_q + XW'(1) < cnt_x) begin
						wa_s1 <= ptr_q;
						ptr_q <= ptr_q + XW'(1);
					end else begin
						count_q           <= cnt_dec;
						done_q            <= 1'b1;
						res_q.read_data   <= '0;
						res_q.status      <= ST_OK;
						res_q.entry_count <= 7'(cnt_dec);
						state_q           <= S_IDLE;
					end
				end
				S_GET: begin
					done_q            <= 1'b1;
					res_q.read_data   <= rdata_s1;
					res_q.status      <= ST_OK;
					res_q.entry_count <= 7'(count_q);
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still in progress");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> full)
		else $error("full status reported on a list that is not full");

	a_shift_up_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP) |-> (ptr_q >= pos_q && wa_s1 == ptr_q + XW'(1)))
		else $error("upward shift pointer out of step");

	a_shift_dn_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN) |-> (ptr_q < cnt_x && wa_s1 + XW'(1) == ptr_q))
		else $error("downward shift pointer out of step");

endmodule

>>> dv/tb_indexed_shift_list_top.sv
// testbench for the indexed shift list: directed and random requests checked against a shadow list
module tb_indexed_shift_list_top;
	import isl_pkg::*;

	localparam int CAPACITY = 64;
	localparam int MAX_POS = 127;
	localparam int DRAIN_CYCLES = CAPACITY + 20;
	localparam int RUN_LIMIT = 6000000;

	typedef enum int {
		PHASE_GROW,
		PHASE_SHRINK,
		PHASE_MIXED,
		PHASE_EDIT
	} phase_e;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t result;

	logic signed [31:0] shadow_list[$];
	res_t pending_results[$];
	int mismatches;
	bit no_gaps;

	indexed_shift_list_top #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic res_t apply_to_shadow(input cmd_t c);
		res_t r;
		int p;
		r.read_data = '0;
		r.status = ST_OK;
		p = int'(c.position);
		case (c.kind)
			KIND_APPEND: begin
				if (shadow_list.size() >= CAPACITY)
					r.status = ST_FULL;
				else
					shadow_list.push_back(c.value);
			end
			KIND_INSERT: begin
				if (p > shadow_list.size())
					r.status = ST_RANGE;
				else if (shadow_list.size() >= CAPACITY)
					r.status = ST_FULL;
				else
					shadow_list.insert(p, c.value);
			end
			KIND_REMOVE: begin
				if (p >= shadow_list.size())
					r.status = ST_RANGE;
				else
					shadow_list.delete(p);
			end
			KIND_SET: begin
				if (p >= shadow_list.size())
					r.status = ST_RANGE;
				else
					shadow_list[p] = c.value;
			end
			KIND_GET: begin
				if (p >= shadow_list.size()) begin
					r.status = ST_RANGE;
					r.read_data = BAD_READ;
				end else begin
					r.read_data = shadow_list[p];
				end
			end
			default: ;
		endcase
		r.entry_count = 7'(shadow_list.size());
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 45)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// one transfer, then an optional idle stretch with start low
	task automatic send_cmd(input logic [2:0] kind, input int pos, input logic signed [31:0] value);
		cmd_t c;
		int gap;
		c.kind = kind;
		c.position = pos[6:0];
		c.value = value;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_to_shadow(c));
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= cmd_t'(42'({$urandom, $urandom}));
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.read_data !== want.read_data)
					report_mismatch("read_data", result.read_data, want.read_data);
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.entry_count !== want.entry_count)
					report_mismatch("entry_count", result.entry_count, want.entry_count);
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_position(input logic [2:0] kind);
		int n;
		n = shadow_list.size();
		if ($urandom_range(0, 99) < 15)
			return $urandom_range(0, MAX_POS);
		if (kind == KIND_INSERT)
			return $urandom_range(0, n);
		if (n == 0)
			return 0;
		return $urandom_range(0, n - 1);
	endfunction

	function automatic logic [2:0] pick_kind(input phase_e phase);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return 3'($urandom_range(5, 7));
		roll = $urandom_range(0, 99);
		case (phase)
			PHASE_GROW: begin
				if (roll < 35) return KIND_APPEND;
				if (roll < 70) return KIND_INSERT;
				if (roll < 80) return KIND_REMOVE;
				if (roll < 90) return KIND_SET;
				return KIND_GET;
			end
			PHASE_SHRINK: begin
				if (roll < 10) return KIND_APPEND;
				if (roll < 20) return KIND_INSERT;
				if (roll < 75) return KIND_REMOVE;
				if (roll < 85) return KIND_SET;
				return KIND_GET;
			end
			PHASE_EDIT: begin
				if (roll < 10) return KIND_APPEND;
				if (roll < 20) return KIND_INSERT;
				if (roll < 30) return KIND_REMOVE;
				if (roll < 60) return KIND_SET;
				return KIND_GET;
			end
			default: return 3'($urandom_range(0, 4));
		endcase
	endfunction

	task automatic test_empty_list();
		send_cmd(KIND_GET, 0, 32'sd0);
		send_cmd(KIND_GET, MAX_POS, 32'sd0);
		send_cmd(KIND_REMOVE, 0, 32'sd0);
		send_cmd(KIND_SET, 0, 32'sh7fff_ffff);
		send_cmd(KIND_INSERT, 1, 32'sd5);
		send_cmd(3'd5, 0, 32'sd1);
		send_cmd(3'd6, MAX_POS, -32'sd1);
		send_cmd(3'd7, 64, 32'sh8000_0000);
	endtask

	task automatic test_basic_ops();
		send_cmd(KIND_APPEND, MAX_POS, 32'sh8000_0000);
		send_cmd(KIND_APPEND, 0, 32'sh7fff_ffff);
		send_cmd(KIND_INSERT, 0, -32'sd1);
		send_cmd(KIND_INSERT, 3, 32'sd0);
		send_cmd(KIND_INSERT, 2, 32'sh5555_aaaa);
		send_cmd(KIND_INSERT, 6, 32'sd9);
		send_cmd(KIND_SET, 1, 32'shaaaa_5555);
		send_cmd(KIND_SET, 5, 32'sd1);
		send_cmd(KIND_GET, 0, 32'sd0);
		send_cmd(KIND_GET, 1, 32'sd0);
		send_cmd(KIND_GET, 4, 32'sd0);
		send_cmd(KIND_GET, 5, 32'sd0);
		send_cmd(KIND_REMOVE, 2, 32'sd0);
		send_cmd(KIND_REMOVE, 3, 32'sd0);
		send_cmd(KIND_REMOVE, 0, 32'sd0);
		send_cmd(KIND_GET, 2, 32'sd0);
		send_cmd(KIND_GET, 3, 32'sd0);
	endtask

	task automatic test_full_list();
		logic [2:0] k;
		while (shadow_list.size() < CAPACITY) begin
			k = ($urandom_range(0, 1) == 0) ? KIND_APPEND : KIND_INSERT;
			send_cmd(k, $urandom_range(0, shadow_list.size()), pick_value());
		end
		send_cmd(KIND_APPEND, 0, 32'sd7);
		send_cmd(KIND_INSERT, 0, 32'sd7);
		send_cmd(KIND_INSERT, CAPACITY, 32'sd7);
		send_cmd(KIND_INSERT, CAPACITY + 1, 32'sd7);
		send_cmd(KIND_GET, CAPACITY - 1, 32'sd0);
		send_cmd(KIND_GET, CAPACITY, 32'sd0);
		send_cmd(KIND_SET, CAPACITY - 1, 32'sh8000_0000);
		send_cmd(KIND_REMOVE, 0, 32'sd0);
		send_cmd(KIND_INSERT, 0, 32'sh7fff_ffff);
		send_cmd(KIND_GET, 0, 32'sd0);
		send_cmd(KIND_GET, CAPACITY - 1, 32'sd0);
		send_cmd(KIND_REMOVE, CAPACITY - 1, 32'sd0);
		send_cmd(KIND_INSERT, CAPACITY - 1, -32'sd1);
		send_cmd(KIND_GET, CAPACITY - 1, 32'sd0);
	endtask

	task automatic test_random_traffic(input int n_items);
		phase_e phase;
		logic [2:0] k;
		for (int i = 0; i < n_items; i++) begin
			phase = phase_e'((i / 50) % 4);
			no_gaps = ((i / 25) % 4) == 3;
			k = pick_kind(phase);
			send_cmd(k, pick_position(k), pick_value());
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		mismatches = 0;
		no_gaps = 1'b0;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(negedge clk);
		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_random_traffic(300);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAILURE");
		$finish;
	end

endmodule
